// ===== src/spfl_pkg.sv =====
package spfl_pkg;

    localparam int KIND_W  = 2;
    localparam int IDX_W   = 6;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;
    localparam int SSTATE_W = 2;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] STAT_WRONG = 2'd3;

    // per-slot state codes
    localparam logic [SSTATE_W-1:0] SLOT_FREE     = 2'd0;
    localparam logic [SSTATE_W-1:0] SLOT_ALLOC    = 2'd1;
    localparam logic [SSTATE_W-1:0] SLOT_DETACHED = 2'd2;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic exec_fire;
    } spfl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_valid;
    } spfl_sts_t;

endpackage

// ===== src/spfl_ctrl.sv =====
module spfl_ctrl
    import spfl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       m_tready,
    input  spfl_sts_t  sts,
    output logic       s_tready,
    output spfl_cmd_t  cmd
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready       = (state_reg == ST_IDLE);
    assign cmd.clear_step = (state_reg == ST_CLEAR);
    assign cmd.accept     = (state_reg == ST_IDLE) && s_tvalid;
    // the output register must be empty or draining before a result is committed
    assign cmd.exec_fire  = (state_reg == ST_EXEC) && (!sts.out_valid || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (cmd.exec_fire) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/spfl_datapath.sv =====
module spfl_datapath
    import spfl_pkg::*;
#(
    parameter int SLOT_COUNT = 64
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  spfl_cmd_t           cmd,
    output spfl_sts_t           sts,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [IDX_W-1:0]    in_slot_index,
    input  logic                m_tready,
    output logic                out_valid,
    output logic [STAT_W-1:0]   out_status,
    output logic [IDX_W-1:0]    out_slot,
    output logic [COUNT_W-1:0]  out_in_use_count
);

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int XW = (IW > IDX_W) ? IW : IDX_W;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOT_COUNT - 1);

    // link and state memories
    logic [IW-1:0]       next_mem  [SLOT_COUNT];
    logic [IW-1:0]       prev_mem  [SLOT_COUNT];
    logic [SSTATE_W-1:0] state_mem [SLOT_COUNT];

    logic [IW-1:0]       next_rd_reg;
    logic [IW-1:0]       prev_rd_reg;
    logic [SSTATE_W-1:0] state_rd_reg;

    logic [KIND_W-1:0]   kind_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic                nonempty_reg, nonempty_next;
    logic [CW-1:0]       total_reg, total_next;
    logic [IW-1:0]       clr_cnt_reg;

    logic                out_valid_reg;
    logic [STAT_W-1:0]   out_status_reg;
    logic [IDX_W-1:0]    out_slot_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic [XW-1:0]       in_idx_x;
    logic [IW-1:0]       in_addr;
    logic [XW-1:0]       idx_x;
    logic [IW-1:0]       addr;
    logic                in_range;

    logic                next_we, prev_we, state_we;
    logic [IW-1:0]       next_wa, next_wd, prev_wa, prev_wd, state_wa;
    logic [SSTATE_W-1:0] state_wd;
    logic [STAT_W-1:0]   status_c;
    logic [IDX_W-1:0]    slot_c;

    assign in_idx_x = XW'(in_slot_index);
    assign in_addr  = in_idx_x[IW-1:0];
    assign idx_x    = XW'(idx_reg);
    assign addr     = idx_x[IW-1:0];
    assign in_range = ({1'b0, idx_x} < (XW + 1)'(SLOT_COUNT));

    assign sts.clear_last = (clr_cnt_reg == LAST_SLOT);
    assign sts.out_valid  = out_valid_reg;

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_slot         = out_slot_reg;
    assign out_in_use_count = out_count_reg;

    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        nonempty_next = nonempty_reg;
        total_next    = total_reg;
        next_we  = 1'b0;
        next_wa  = tail_reg;
        next_wd  = addr;
        prev_we  = 1'b0;
        prev_wa  = addr;
        prev_wd  = tail_reg;
        state_we = 1'b0;
        state_wa = addr;
        state_wd = SLOT_FREE;
        status_c = STAT_OK;
        slot_c   = idx_reg;

        if (kind_reg == KIND_ALLOC) begin
            if (!nonempty_reg) begin
                status_c = STAT_EMPTY;
                slot_c   = '0;
            end else begin
                // next_rd_reg holds the link of the head slot
                if (head_reg == tail_reg) begin
                    nonempty_next = 1'b0;
                end else begin
                    head_next = next_rd_reg;
                end
                state_we   = 1'b1;
                state_wa   = head_reg;
                state_wd   = SLOT_ALLOC;
                total_next = total_reg + CW'(1);
                slot_c     = IDX_W'(head_reg);
            end
        end else if (!in_range) begin
            status_c = STAT_RANGE;
        end else begin
            priority case (1'b1)
                (kind_reg == KIND_FREE && state_rd_reg == SLOT_ALLOC),
                (kind_reg == KIND_ADD && state_rd_reg == SLOT_DETACHED): begin
                    // append at the free tail
                    if (nonempty_reg) begin
                        next_we = 1'b1;
                        prev_we = 1'b1;
                    end else begin
                        head_next     = addr;
                        nonempty_next = 1'b1;
                    end
                    tail_next = addr;
                    state_we  = 1'b1;
                    state_wd  = SLOT_FREE;
                    if (kind_reg == KIND_FREE) begin
                        total_next = total_reg - CW'(1);
                    end
                end
                (kind_reg == KIND_REMOVE && state_rd_reg == SLOT_FREE): begin
                    // unlink from anywhere in the free queue
                    if (head_reg == addr && tail_reg == addr) begin
                        nonempty_next = 1'b0;
                    end else if (head_reg == addr) begin
                        head_next = next_rd_reg;
                    end else if (tail_reg == addr) begin
                        tail_next = prev_rd_reg;
                    end else begin
                        next_we = 1'b1;
                        next_wa = prev_rd_reg;
                        next_wd = next_rd_reg;
                        prev_we = 1'b1;
                        prev_wa = next_rd_reg;
                        prev_wd = prev_rd_reg;
                    end
                    state_we = 1'b1;
                    state_wd = SLOT_DETACHED;
                end
                (kind_reg == KIND_REMOVE && state_rd_reg == SLOT_ALLOC): begin
                    state_we   = 1'b1;
                    state_wd   = SLOT_DETACHED;
                    total_next = total_reg - CW'(1);
                end
                default: begin
                    status_c = STAT_WRONG;
                end
            endcase
        end
    end

    // memories: clearing pass writes the reset queue, requests read then write
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            next_mem[clr_cnt_reg]  <= (clr_cnt_reg == LAST_SLOT) ? '0
                                                                 : clr_cnt_reg + IW'(1);
            prev_mem[clr_cnt_reg]  <= (clr_cnt_reg == '0) ? LAST_SLOT
                                                          : clr_cnt_reg - IW'(1);
            state_mem[clr_cnt_reg] <= SLOT_FREE;
        end else if (cmd.exec_fire) begin
            if (next_we) begin
                next_mem[next_wa] <= next_wd;
            end
            if (prev_we) begin
                prev_mem[prev_wa] <= prev_wd;
            end
            if (state_we) begin
                state_mem[state_wa] <= state_wd;
            end
        end
        if (cmd.accept) begin
            next_rd_reg  <= next_mem[(in_kind == KIND_ALLOC) ? head_reg : in_addr];
            prev_rd_reg  <= prev_mem[in_addr];
            state_rd_reg <= state_mem[in_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg <= in_kind;
            idx_reg  <= in_slot_index;
        end
        if (cmd.exec_fire) begin
            out_status_reg <= status_c;
            out_slot_reg   <= slot_c;
            out_count_reg  <= COUNT_W'(total_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            tail_reg      <= LAST_SLOT;
            nonempty_reg  <= 1'b1;
            total_reg     <= '0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
            end
            if (cmd.exec_fire) begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                nonempty_reg <= nonempty_next;
                total_reg    <= total_next;
            end
            if (cmd.exec_fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== src/slot_pool_free_list_allocator_core.sv =====
// Fixed pool of SLOT_COUNT slots with a first-in first-out free list held in
// link memories. Each request (alloc, free, add, remove) gives one result with
// a status, the slot and the in-use count. After reset the block runs a
// clearing pass over every entry of the link and state memories, with
// s_tready low; afterwards a request first reads the slot's state and links
// from the memories, then updates them and the head/tail pointers once the
// output register is empty or draining. A new request is accepted while the
// previous result still waits in the output register.
module slot_pool_free_list_allocator_core
    import spfl_pkg::*;
#(
    parameter int SLOT_COUNT = 64
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [5:0] slot_index, [7:6] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [7:2] slot, [14:8] in_use_count, [15] zero
);

    spfl_cmd_t          cmd;
    spfl_sts_t          sts;
    logic [STAT_W-1:0]  out_status;
    logic [IDX_W-1:0]   out_slot;
    logic [COUNT_W-1:0] out_count;

    spfl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    spfl_datapath #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .in_kind          (s_tuser),
        .in_slot_index    (s_tdata[IDX_W-1:0]),
        .m_tready         (m_tready),
        .out_valid        (m_tvalid),
        .out_status       (out_status),
        .out_slot         (out_slot),
        .out_in_use_count (out_count)
    );

    assign m_tdata = {1'b0, out_count, out_slot, out_status};

endmodule
